// File: sv/kgrw_pkg.sv
package kgrw_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD_COORD = 2'd0,
      FUNC_LOAD_NB    = 2'd1,
      FUNC_START      = 2'd2,
      FUNC_NEXT       = 2'd3
   } func_type;

   localparam int unsigned FUNC_BITS     = 2;
   localparam int unsigned PIDX_BITS     = 10;
   localparam int unsigned SLOT_BITS     = 3;
   localparam int unsigned COORD_W       = 16;
   localparam int unsigned FOUND_BITS    = 11;
   localparam int unsigned RADIUS_BITS   = 36;
   localparam int unsigned DIST_BITS     = 64;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  func;
      logic [PIDX_BITS-1:0]  point_index;
      logic [SLOT_BITS-1:0]  slot;
      logic [COORD_W-1:0]    coordinate;
      logic [PIDX_BITS-1:0]  neighbor_index;
   } req_type;

   typedef struct packed {
      logic [FOUND_BITS-1:0] found_index;
      logic                  exhausted;
      logic                  is_answer;
   } rsp_type;

   // Controller to datapath commands
   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_START,
      CMD_MARK,
      CMD_POP,
      CMD_CUR,
      CMD_NB_RD,
      CMD_NB_CHK,
      CMD_CO_RD,
      CMD_ACC,
      CMD_DECIDE
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [5:0]   step;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic nb_skip;
      logic clear_done;
      logic query_bad;
   } status_type;

endpackage

// File: sv/kgrw_if.sv
interface kgrw_req_if;
   import kgrw_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface kgrw_rsp_if;
   import kgrw_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface kgrw_csr_if;
   import kgrw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [RADIUS_BITS-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/kgrw_ram.sv
module kgrw_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: sv/kgrw_datapath.sv
module kgrw_datapath #(
   parameter int unsigned NUM_POINTS    = 1024,
   parameter int unsigned NUM_NEIGHBORS = 8,
   parameter int unsigned DIMENSIONS    = 3,
   parameter int unsigned COORD_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kgrw_pkg::cmd_type                    cmd,
   input  kgrw_pkg::req_type                    req,
   input  logic [kgrw_pkg::RADIUS_BITS-1:0]     radius,
   output kgrw_pkg::status_type                 status,
   output logic [kgrw_pkg::FOUND_BITS-1:0]      cur_index
);
   import kgrw_pkg::*;

   localparam int unsigned PW   = $clog2(NUM_POINTS);
   localparam int unsigned DW   = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
   localparam int unsigned CD   = NUM_POINTS * DIMENSIONS;
   localparam int unsigned ND   = NUM_POINTS * NUM_NEIGHBORS;
   localparam int unsigned CAW  = $clog2(CD);
   localparam int unsigned NAW  = $clog2(ND);
   localparam int unsigned SW   = PW + 1;
   localparam int unsigned DIFW = COORD_BITS + 1;
   localparam int unsigned SQW  = 2 * DIFW;

   // Memories
   logic           co_we, nb_we, vf_we, st_we;
   logic [CAW-1:0] co_wa, co_ra;
   logic [NAW-1:0] nb_wa, nb_ra;
   logic [PW-1:0]  vf_wa, vf_ra, st_wa, st_ra;
   logic [COORD_BITS-1:0] co_wd, co_rd;
   logic [PIDX_BITS-1:0]  nb_wd, nb_rd;
   logic           vf_wd, vf_rd;
   logic [PW-1:0]  st_wd, st_rd;

   kgrw_ram #(.WIDTH(COORD_BITS), .DEPTH(CD)) u_coord (
      .clock, .wr_en(co_we), .wr_addr(co_wa), .wr_data(co_wd),
      .rd_addr(co_ra), .rd_data(co_rd));
   kgrw_ram #(.WIDTH(PIDX_BITS), .DEPTH(ND)) u_nb (
      .clock, .wr_en(nb_we), .wr_addr(nb_wa), .wr_data(nb_wd),
      .rd_addr(nb_ra), .rd_data(nb_rd));
   kgrw_ram #(.WIDTH(1), .DEPTH(NUM_POINTS)) u_visit (
      .clock, .wr_en(vf_we), .wr_addr(vf_wa), .wr_data(vf_wd),
      .rd_addr(vf_ra), .rd_data(vf_rd));
   kgrw_ram #(.WIDTH(PW), .DEPTH(NUM_POINTS)) u_stack (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));

   logic [SW-1:0]         depth_ff, depth_in;
   logic [PIDX_BITS-1:0]  query_ff, query_in;
   logic [PW-1:0]         cur_ff, cur_in;
   logic [PW-1:0]         nb_ff, nb_in;
   logic [PW:0]           clr_ff, clr_in;
   logic signed [COORD_BITS-1:0] qco_ff, qco_in;
   logic signed [SQW-1:0] sq_ff, sq_in;
   logic [DIST_BITS-1:0]  sum_ff, sum_in;
   logic                  nb_ok_ff, nb_ok_in;

   wire query_ok = {{(32-PIDX_BITS){1'b0}}, query_ff} < NUM_POINTS;
   wire [PW-1:0] qidx = query_ff[PW-1:0];
   wire [5:0]   st   = cmd.step;
   wire [DW-1:0] ax  = st[DW-1:0] ;
   wire signed [DIFW-1:0] diff =
      DIFW'(co_rd) - DIFW'(qco_ff) + ({DIFW{1'b0}});
   logic signed [DIFW-1:0] dsx;

   always_comb begin
      dsx = $signed({co_rd[COORD_BITS-1], co_rd}) -
            $signed({qco_ff[COORD_BITS-1], qco_ff});
   end

   // Command decode
   always_comb begin
      co_we = 1'b0; nb_we = 1'b0; vf_we = 1'b0; st_we = 1'b0;
      co_wa = CAW'(req.point_index * DIMENSIONS + req.slot);
      co_wd = req.coordinate[COORD_BITS-1:0];
      nb_wa = NAW'(req.point_index * NUM_NEIGHBORS + req.slot);
      nb_wd = req.neighbor_index;
      co_ra = '0; nb_ra = '0; vf_ra = nb_rd[PW-1:0]; st_ra = depth_ff[PW-1:0];
      vf_wa = clr_ff[PW-1:0]; vf_wd = 1'b0;
      st_wa = depth_ff[PW-1:0]; st_wd = qidx;
      depth_in = depth_ff; query_in = query_ff; cur_in = cur_ff;
      nb_in = nb_ff; clr_in = clr_ff; qco_in = qco_ff; sq_in = sq_ff;
      sum_in = sum_ff; nb_ok_in = nb_ok_ff;
      case (cmd.code)
         CMD_LOAD: begin
            if ({{(32-PIDX_BITS){1'b0}}, req.point_index} < NUM_POINTS) begin
               if (req.func == FUNC_LOAD_COORD &&
                   32'(req.slot) < DIMENSIONS) co_we = 1'b1;
               if (req.func == FUNC_LOAD_NB &&
                   32'(req.slot) < NUM_NEIGHBORS) nb_we = 1'b1;
            end
         end
         CMD_CLEAR: begin
            vf_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         CMD_START: begin
            clr_in = '0;
            query_in = req.point_index;
            depth_in = '0;
            if ({{(32-PIDX_BITS){1'b0}}, req.point_index} < NUM_POINTS) begin
               st_we = 1'b1; st_wa = '0; st_wd = req.point_index[PW-1:0];
               vf_we = 1'b1; vf_wa = req.point_index[PW-1:0]; vf_wd = 1'b1;
               depth_in = SW'(1);
            end
         end
         CMD_MARK: begin
            // push and mark the held query point once the sweep is over
            clr_in = '0;
            depth_in = '0;
            if (query_ok) begin
               st_we = 1'b1; st_wa = '0; st_wd = qidx;
               vf_we = 1'b1; vf_wa = qidx; vf_wd = 1'b1;
               depth_in = SW'(1);
            end
         end
         CMD_POP: begin
            depth_in = depth_ff - 1'b1;
            st_ra = PW'(depth_ff - 1'b1);
         end
         CMD_CUR: begin
            cur_in = st_rd;
         end
         CMD_NB_RD: begin
            nb_ra = NAW'(cur_ff * NUM_NEIGHBORS + st);
         end
         CMD_NB_CHK: begin
            // neighbor valid bit: visited read issued now
            nb_in = nb_rd[PW-1:0];
            nb_ok_in = {{(32-PIDX_BITS){1'b0}}, nb_rd} < NUM_POINTS;
            sum_in = '0;
         end
         CMD_CO_RD: begin
            // step: even = query coord read, odd = neighbor coord read
            if (st[0] == 1'b0)
               co_ra = CAW'(qidx * DIMENSIONS + st[5:1]);
            else
               co_ra = CAW'(nb_ff * DIMENSIONS + st[5:1]);
            if (st == 6'd0) nb_ok_in = nb_ok_ff & ~vf_rd;
            if (st[0] == 1'b1) qco_in = co_rd;
            if (st[0] == 1'b0 && st != 6'd0) sq_in = SQW'(dsx) * SQW'(dsx);
         end
         CMD_ACC: begin
            // keep the pending query coordinate read on the port
            co_ra = CAW'(qidx * DIMENSIONS + st[5:1]);
            sum_in = sum_ff + DIST_BITS'(unsigned'(sq_ff));
         end
         CMD_DECIDE: begin
            if (nb_ok_ff && sum_ff < DIST_BITS'(radius) &&
                depth_ff < SW'(NUM_POINTS)) begin
               st_we = 1'b1; st_wa = depth_ff[PW-1:0]; st_wd = nb_ff;
               vf_we = 1'b1; vf_wa = nb_ff; vf_wd = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Hold walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         query_ff <= '0;
         clr_ff   <= '0;
      end else begin
         depth_ff <= depth_in;
         query_ff <= query_in;
         clr_ff   <= clr_in;
      end
      cur_ff <= cur_in; nb_ff <= nb_in; qco_ff <= qco_in;
      sq_ff <= sq_in; sum_ff <= sum_in; nb_ok_ff <= nb_ok_in;
   end

   assign status.empty      = (depth_ff == '0) || !query_ok;
   assign status.nb_skip    = !nb_ok_ff;
   assign status.clear_done = clr_ff[PW];
   assign status.query_bad  = !query_ok;
   assign cur_index = FOUND_BITS'(cur_ff);

   logic unused_ok;
   assign unused_ok = ^{diff, ax};
endmodule

// File: sv/kgrw_ctrl.sv
module kgrw_ctrl #(
   parameter int unsigned NUM_POINTS    = 1024,
   parameter int unsigned NUM_NEIGHBORS = 8,
   parameter int unsigned DIMENSIONS    = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_fire,
   input  kgrw_pkg::func_type          req_func,
   input  logic                        rsp_ready,
   input  kgrw_pkg::status_type        status,
   input  logic [kgrw_pkg::FOUND_BITS-1:0] cur_index,
   output logic                        busy,
   output kgrw_pkg::cmd_type           cmd,
   output logic                        rsp_valid,
   output kgrw_pkg::rsp_type           rsp
);
   import kgrw_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_POP, S_CUR, S_NB_RD, S_NB_CHK,
      S_CO, S_ACC, S_DECIDE
   } state_type;

   localparam int unsigned COSTEPS = 2 * DIMENSIONS + 1;

   state_type state_ff, state_in;
   logic [5:0] k_ff, k_in, d_ff, d_in;
   logic       rv_ff, rv_in;
   rsp_type    rsp_ff, rsp_in;
   logic       acc_ff, acc_in;

   assign busy = (state_ff != S_IDLE) || (rv_ff && !rsp_ready);

   // Sequence the walk
   always_comb begin
      state_in = state_ff; k_in = k_ff; d_in = d_ff; acc_in = 1'b0;
      rv_in = rv_ff && !rsp_ready; rsp_in = rsp_ff;
      cmd.code = CMD_IDLE; cmd.step = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  FUNC_LOAD_COORD, FUNC_LOAD_NB: begin
                     cmd.code = CMD_LOAD;
                     rv_in = 1'b1; rsp_in = '0;
                  end
                  FUNC_START: begin
                     cmd.code = CMD_START;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     if (status.empty) begin
                        rv_in = 1'b1;
                        rsp_in.found_index = FOUND_BITS'(NUM_POINTS);
                        rsp_in.exhausted = 1'b1; rsp_in.is_answer = 1'b1;
                     end else begin
                        cmd.code = CMD_POP;
                        state_in = S_POP;
                     end
                  end
               endcase
            end
         end
         S_CLEAR: begin
            // Sweep visited flags; start point is re-marked afterwards
            if (status.clear_done) begin
               cmd.code = CMD_MARK;
               state_in = S_IDLE;
               rv_in = 1'b1; rsp_in = '0;
            end else begin
               cmd.code = CMD_CLEAR;
            end
         end
         S_POP: state_in = S_CUR;
         S_CUR: begin
            cmd.code = CMD_CUR;
            k_in = '0;
            state_in = S_NB_RD;
         end
         S_NB_RD: begin
            cmd.code = CMD_NB_RD; cmd.step = k_ff;
            state_in = S_NB_CHK;
         end
         S_NB_CHK: begin
            cmd.code = CMD_NB_CHK;
            d_in = '0;
            state_in = S_CO;
         end
         S_CO: begin
            cmd.code = CMD_CO_RD; cmd.step = d_ff;
            if (d_ff == 6'(COSTEPS)) begin
               state_in = S_ACC;
            end else begin
               d_in = d_ff + 1'b1;
               if (d_ff[0] == 1'b0 && d_ff != 6'd0) state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.code = CMD_ACC; cmd.step = d_ff;
            state_in = (d_ff == 6'(COSTEPS)) ? S_DECIDE : S_CO;
            if (d_ff == 6'(COSTEPS)) d_in = d_ff + 1'b1;
         end
         S_DECIDE: begin
            cmd.code = CMD_DECIDE;
            if (k_ff == 6'(NUM_NEIGHBORS - 1)) begin
               state_in = S_IDLE;
               rv_in = 1'b1;
               rsp_in.found_index = cur_index;
               rsp_in.exhausted = 1'b0; rsp_in.is_answer = 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = S_NB_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         k_ff     <= '0;
         d_ff     <= '0;
         acc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         k_ff     <= k_in;
         d_ff     <= d_in;
         acc_ff   <= acc_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp       = rsp_ff;

   logic unused_ok;
   assign unused_ok = ^{acc_ff, status.nb_skip, status.query_bad};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_fire) else $error("accept while walking");
   a_rsp_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && k_ff == 6'(NUM_NEIGHBORS - 1)) |=> rv_ff)
      else $error("missing answer");
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_ff.exhausted) |-> rsp_ff.is_answer)
      else $error("end marker not an answer");
endmodule

// File: sv/knn_graph_radius_walk.sv
// Channel | Dir | Payload                                       | Handshake
// req     | in  | func, point_index, slot, coordinate, nb index | valid/ready
// rsp     | out | found_index, exhausted, is_answer             | valid/ready
// csr     | in  | squared_radius (36 bits)                      | valid/ready
// A start sweeps the visited flags. A next item reads the coordinate memory
// twice per axis (query and neighbour) for each neighbour.
// Reset is synchronous and clears the stack depth, query point and control.
// One item at a time; the result register holds until rsp_ready.
module knn_graph_radius_walk #(
   parameter int unsigned NUM_POINTS    = 1024,
   parameter int unsigned NUM_NEIGHBORS = 8,
   parameter int unsigned DIMENSIONS    = 3,
   parameter int unsigned COORD_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   kgrw_req_if.sink    req,
   kgrw_rsp_if.source  rsp,
   kgrw_csr_if.sink    csr
);
   import kgrw_pkg::*;

   logic [RADIUS_BITS-1:0] radius_ff;
   cmd_type    cmd;
   status_type status;
   logic [FOUND_BITS-1:0] cur_index;
   logic       busy;

   assign req.ready = !busy;
   assign csr.ready = 1'b1;

   // Hold the radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr.valid) begin
         radius_ff <= csr.data;
      end
   end

   kgrw_ctrl #(.NUM_POINTS(NUM_POINTS), .NUM_NEIGHBORS(NUM_NEIGHBORS),
      .DIMENSIONS(DIMENSIONS)) u_ctrl (
      .clock, .reset,
      .req_fire(req.valid && req.ready),
      .req_func(func_type'(req.payload.func)),
      .rsp_ready(rsp.ready), .status, .cur_index, .busy, .cmd,
      .rsp_valid(rsp.valid), .rsp(rsp.payload));

   kgrw_datapath #(.NUM_POINTS(NUM_POINTS), .NUM_NEIGHBORS(NUM_NEIGHBORS),
      .DIMENSIONS(DIMENSIONS), .COORD_BITS(COORD_BITS)) u_dp (
      .clock, .reset, .cmd, .req(req.payload), .radius(radius_ff),
      .status, .cur_index);
endmodule
